[hdl/priority_quantum_scheduler_assert.svh]
// Assertion macros used by the checker file.
`ifndef PRIORITY_QUANTUM_SCHEDULER_ASSERT_SVH
`define PRIORITY_QUANTUM_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PQS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pqs assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PQS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pqs assertion failed");

`endif

[hdl/pqs_pkg.sv]
package pqs_pkg;

  // request kinds
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_SLICE = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_ADDED = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RUN   = 2'd2;
  localparam logic [1:0] STAT_IDLE  = 2'd3;

  localparam logic [15:0] QUANTUM_RESET = 16'd1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  proc_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  priority_req;
  } sched_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  run_id;
    logic [7:0]  run_priority;
    logic [15:0] remaining;
    logic        finished;
    logic [31:0] now;
  } sched_out_t;

  // one process table entry
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [7:0]  prio;
    logic [7:0]  seq;
  } slot_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FREE,
    ST_ADD,
    ST_FIRST_RD,
    ST_FIRST_CAP,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic free_step;
    logic add_commit;
    logic first_read;
    logic first_capture;
    logic scan_issue;
    logic update;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic req_slice;
    logic free_hit;
    logic idx_last;
    logic first_done;
    logic earliest_valid;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/pqs_ram.sv]
module pqs_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/pqs_ctrl.sv]
module pqs_ctrl import pqs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!stat.req_slice) begin
          state_nxt = ST_FREE;
        end else if (stat.first_done) begin
          state_nxt = ST_SCAN;
        end else if (stat.earliest_valid) begin
          state_nxt = ST_FIRST_RD;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_FREE: begin
        if (stat.free_hit || stat.idx_last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD:       state_nxt = ST_DONE;
      ST_FIRST_RD:  state_nxt = ST_FIRST_CAP;
      ST_FIRST_CAP: state_nxt = ST_UPDATE;
      ST_SCAN: begin
        if (stat.idx_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:     state_nxt = ST_UPDATE;
      ST_UPDATE:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_FREE:      cmd.free_step     = 1'b1;
      ST_ADD:       cmd.add_commit    = 1'b1;
      ST_FIRST_RD:  cmd.first_read    = 1'b1;
      ST_FIRST_CAP: cmd.first_capture = 1'b1;
      ST_SCAN:      cmd.scan_issue    = 1'b1;
      ST_UPDATE:    cmd.update        = 1'b1;
      ST_DONE:      cmd.load_out      = stat.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

[hdl/pqs_dp.sv]
module pqs_dp import pqs_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sched_in_t   in_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        out_stall,
  output logic        out_valid,
  output sched_out_t  out_data,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat
);

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);

  logic [15:0]          quantum_r;
  logic [MAX_PROCS-1:0] valid_r;
  sched_in_t            req_r;
  logic [7:0]           add_cnt_r;
  logic [31:0]          now_r, now_nxt;
  logic [IDX_W-1:0]     earliest_r;
  logic [15:0]          earliest_arr_r;
  logic                 first_done_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     best_slot_r;
  slot_entry_t          best_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_slot_r;
  sched_out_t           res_r, out_r;
  logic                 out_valid_r;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_raddr;
  slot_entry_t      ram_wdata, ram_rdata;

  logic        free_hit;
  logic [7:0]  cand_age, best_age;
  logic        cand_ok;
  logic        fin;
  logic [15:0] rem_sub, step;
  logic [32:0] sum;
  logic        earliest_upd;

  pqs_ram #(
    .WIDTH($bits(slot_entry_t)),
    .DEPTH(MAX_PROCS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(best_slot_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign free_hit = !valid_r[idx_r];

  // scan compare on the registered read data
  assign cand_age = add_cnt_r - ram_rdata.seq;
  assign best_age = add_cnt_r - best_r.seq;
  assign cand_ok  = valid_r[cmp_slot_r] && ({16'd0, ram_rdata.arrival} <= now_r) &&
                    (!found_r || (ram_rdata.prio < best_r.prio) ||
                     ((ram_rdata.prio == best_r.prio) && (cand_age > best_age)));

  // slice bookkeeping
  assign fin     = best_r.remaining <= quantum_r;
  assign rem_sub = best_r.remaining - quantum_r;
  assign step    = (found_r && fin) ? best_r.remaining : quantum_r;
  assign sum     = {1'b0, now_r} + {17'd0, step};
  assign now_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  // before the first slice the table only fills upward, so slot 0 means empty table
  assign earliest_upd = !first_done_r && found_r &&
                        ((best_slot_r == '0) || (req_r.arrival_time < earliest_arr_r));

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = best_r;
    if (cmd.add_commit && found_r) begin
      ram_we              = 1'b1;
      ram_wdata.id        = req_r.proc_id;
      ram_wdata.arrival   = req_r.arrival_time;
      ram_wdata.remaining = req_r.burst_time;
      ram_wdata.prio      = req_r.priority_req;
      ram_wdata.seq       = add_cnt_r;
    end else if (cmd.update && found_r && !fin) begin
      ram_we              = 1'b1;
      ram_wdata.remaining = rem_sub;
    end
  end

  assign ram_re    = cmd.first_read || cmd.scan_issue;
  assign ram_raddr = cmd.first_read ? earliest_r : idx_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r    <= QUANTUM_RESET;
      valid_r      <= '0;
      add_cnt_r    <= '0;
      now_r        <= '0;
      earliest_r   <= '0;
      first_done_r <= 1'b0;
      idx_r        <= '0;
      found_r      <= 1'b0;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
      cmp_vld_r <= cmd.scan_issue;
      if (cmd.capture) begin
        found_r <= 1'b0;
        idx_r   <= '0;
      end
      if (cmd.free_step) begin
        if (free_hit) begin
          found_r <= 1'b1;
        end else if (idx_r != LAST_IDX) begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      if (cmd.add_commit && found_r) begin
        valid_r[best_slot_r] <= 1'b1;
        add_cnt_r            <= add_cnt_r + 8'd1;
        if (earliest_upd) begin
          earliest_r <= best_slot_r;
        end
      end
      if (cmd.first_capture) begin
        found_r      <= 1'b1;
        first_done_r <= 1'b1;
      end
      if (cmd.scan_issue && (idx_r != LAST_IDX)) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmp_vld_r && cand_ok) begin
        found_r <= 1'b1;
      end
      if (cmd.update) begin
        now_r <= now_nxt;
        if (found_r && fin) begin
          valid_r[best_slot_r] <= 1'b0;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmp_slot_r <= idx_r;
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.free_step && free_hit) begin
      best_slot_r <= idx_r;
    end
    if (cmd.add_commit) begin
      if (earliest_upd) begin
        earliest_arr_r <= req_r.arrival_time;
      end
      res_r.status       <= found_r ? STAT_ADDED : STAT_FULL;
      res_r.run_id       <= '0;
      res_r.run_priority <= '0;
      res_r.remaining    <= '0;
      res_r.finished     <= 1'b0;
      res_r.now          <= now_r;
    end
    if (cmd.first_capture) begin
      best_r      <= ram_rdata;
      best_slot_r <= earliest_r;
    end
    if (cmp_vld_r && cand_ok) begin
      best_r      <= ram_rdata;
      best_slot_r <= cmp_slot_r;
    end
    if (cmd.update) begin
      res_r.now <= now_nxt;
      if (found_r) begin
        res_r.status       <= STAT_RUN;
        res_r.run_id       <= best_r.id;
        res_r.run_priority <= best_r.prio;
        res_r.remaining    <= fin ? 16'd0 : rem_sub;
        res_r.finished     <= fin;
      end else begin
        res_r.status       <= STAT_IDLE;
        res_r.run_id       <= '0;
        res_r.run_priority <= '0;
        res_r.remaining    <= '0;
        res_r.finished     <= 1'b0;
      end
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.req_slice      = (req_r.cmd == CMD_SLICE);
  assign stat.free_hit       = free_hit;
  assign stat.idx_last       = (idx_r == LAST_IDX);
  assign stat.first_done     = first_done_r;
  assign stat.earliest_valid = valid_r[earliest_r];
  assign stat.out_free       = !out_valid_r || !out_stall;

endmodule

[hdl/priority_quantum_scheduler.sv]
// Priority scheduler with a time quantum over a table of MAX_PROCS processes. An add request
// stores a process in the lowest free slot (status full when none is free); a slice request
// runs one quantum: the very first slice goes to the earliest-arriving process added so far,
// later slices to the arrived process with the smallest priority number, oldest add first on
// ties. The table lives in one RAM read one slot per cycle. An add searches the valid bits for
// a free slot; a later slice scans the full table through the RAM read port; the first slice
// reads only the earliest-arriving slot, and a slice on an empty table before any dispatch
// reads no slot. A finished result sits in the output register while the next request is
// taken. The user must write the quantum register (cfg_wr_en / cfg_wr_data) only
// while the block is idle; the block does not enforce this. It resets to 1.
module priority_quantum_scheduler import pqs_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  sched_in_t   in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output sched_out_t  out_data,
  // quantum register
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer: decode, slot search / table scan, commit, hand-off
  pqs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // process table, best-candidate tracking, time keeping, result register
  pqs_dp #(
    .MAX_PROCS(MAX_PROCS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

[hdl/pqs_checker.sv]
`include "priority_quantum_scheduler_assert.svh"

module pqs_props import pqs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input sched_out_t out_data
);

  logic [31:0] last_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_now_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_now_r <= out_data.now;
    end
  end

  // a held result stays up and unchanged
  `PQS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `PQS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  // one request at a time: the port closes right after a take
  `PQS_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)
  // time never runs backward between results
  `PQS_ASSERT_SAME(a_time_monotone, out_valid, out_data.now >= last_now_r)

endmodule

bind priority_quantum_scheduler pqs_props u_pqs_props (.*);

[tb/pqs_checker.sv]
`timescale 1ns / 1ps
module pqs_checker import pqs_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  sched_in_t   in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  sched_out_t  out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          mismatches,
  output int          outstanding,
  output logic [31:0] sched_time,
  output int          n_run,
  output int          n_done,
  output int          n_idle,
  output int          n_full
);

  typedef struct {
    logic [7:0]  pid;
    logic [15:0] arr;
    logic [15:0] left;
    logic [7:0]  prio;
    logic [7:0]  seq;
  } proc_rec_t;

  // shadow of the process table and scheduler state
  bit          busy_slot [SLOTS];
  proc_rec_t   procs [SLOTS];
  logic [15:0] quantum_q;
  logic [7:0]  add_seq;
  logic [31:0] now_t;
  int          first_pick;
  bit          dispatched;

  sched_out_t  due_results [$];
  int          err_cnt, run_cnt, done_cnt, idle_cnt, full_cnt;

  function automatic void bump_time(input logic [15:0] amount);
    logic [32:0] sum;
    sum = {1'b0, now_t} + {17'd0, amount};
    now_t = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic sched_out_t schedule_step(input sched_in_t req);
    sched_out_t res;
    int free_slot;
    int best;
    bit occupied;
    logic [7:0] age_s, age_b;
    res = '0;
    free_slot = -1;
    best = -1;
    occupied = 1'b0;
    if (req.cmd == CMD_ADD) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (busy_slot[s]) occupied = 1'b1;
        else if (free_slot < 0) free_slot = s;
      end
      if (free_slot < 0) begin
        res.status = STAT_FULL;
      end else begin
        busy_slot[free_slot] = 1'b1;
        procs[free_slot].pid = req.proc_id;
        procs[free_slot].arr = req.arrival_time;
        procs[free_slot].left = req.burst_time;
        procs[free_slot].prio = req.priority_req;
        procs[free_slot].seq = add_seq;
        add_seq = add_seq + 8'd1;
        // earliest-arrival pick is only tracked until the first dispatch
        if (!dispatched && (!occupied || !busy_slot[first_pick] ||
            req.arrival_time < procs[first_pick].arr))
          first_pick = free_slot;
        res.status = STAT_ADDED;
      end
      res.now = now_t;
      return res;
    end

    if (!dispatched) begin
      if (busy_slot[first_pick]) begin
        best = first_pick;
        dispatched = 1'b1;
      end
    end else begin
      for (int s = 0; s < SLOTS; s++) begin
        if (busy_slot[s] && {16'd0, procs[s].arr} <= now_t) begin
          if (best < 0) begin
            best = s;
          end else begin
            age_s = add_seq - procs[s].seq;
            age_b = add_seq - procs[best].seq;
            if (procs[s].prio < procs[best].prio ||
                (procs[s].prio == procs[best].prio && age_s > age_b))
              best = s;
          end
        end
      end
    end

    if (best < 0) begin
      bump_time(quantum_q);
      res.status = STAT_IDLE;
    end else begin
      res.status = STAT_RUN;
      res.run_id = procs[best].pid;
      res.run_priority = procs[best].prio;
      if (procs[best].left <= quantum_q) begin
        bump_time(procs[best].left);
        procs[best].left = '0;
        busy_slot[best] = 1'b0;
        res.finished = 1'b1;
      end else begin
        procs[best].left = procs[best].left - quantum_q;
        bump_time(quantum_q);
        res.remaining = procs[best].left;
      end
    end
    res.now = now_t;
    return res;
  endfunction

  always @(posedge clk) begin
    sched_out_t want;
    bit bad;
    if (!rst_n) begin
      foreach (busy_slot[s]) busy_slot[s] = 1'b0;
      quantum_q = QUANTUM_RESET;
      add_seq = '0;
      now_t = '0;
      first_pick = 0;
      dispatched = 1'b0;
      due_results.delete();
      err_cnt = 0;
      run_cnt = 0;
      done_cnt = 0;
      idle_cnt = 0;
      full_cnt = 0;
    end else begin
      if (cfg_wr_en) quantum_q = cfg_wr_data;
      if (in_valid && !in_stall) due_results.push_back(schedule_step(in_data));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result st=%0d id=%0d prio=%0d rem=%0d fin=%0d now=%0d",
                     $realtime, out_data.status, out_data.run_id, out_data.run_priority,
                     out_data.remaining, out_data.finished, out_data.now);
        end else begin
          want = due_results.pop_front();
          bad = (want.status !== out_data.status) || (want.run_id !== out_data.run_id) ||
                (want.run_priority !== out_data.run_priority) ||
                (want.remaining !== out_data.remaining) ||
                (want.finished !== out_data.finished) || (want.now !== out_data.now);
          if (bad) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch exp st=%0d id=%0d prio=%0d rem=%0d fin=%0d now=%0d %s",
                       $realtime, want.status, want.run_id, want.run_priority,
                       want.remaining, want.finished, want.now,
                       $sformatf("got st=%0d id=%0d prio=%0d rem=%0d fin=%0d now=%0d",
                                 out_data.status, out_data.run_id, out_data.run_priority,
                                 out_data.remaining, out_data.finished, out_data.now));
          end
          case (want.status)
            STAT_RUN: begin
              run_cnt++;
              if (want.finished) done_cnt++;
            end
            STAT_IDLE: idle_cnt++;
            STAT_FULL: full_cnt++;
            default: ;
          endcase
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= due_results.size();
    sched_time  <= now_t;
    n_run       <= run_cnt;
    n_done      <= done_cnt;
    n_idle      <= idle_cnt;
    n_full      <= full_cnt;
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import pqs_pkg::*;

  localparam int SLOTS       = 16;
  localparam int SLICE_LAT   = SLOTS + 4;   // table size plus margin, used for the closing wait
  localparam int CYCLE_LIMIT = 400_000;     // watchdog limit for the whole run
  localparam int PHASES      = 10;
  localparam int PHASE_REQS  = 130;
  localparam int SAT_SLICES  = 20;          // closing burst of long-quantum slices
  localparam int IN_W        = $bits(sched_in_t);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sched_in_t   in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sched_out_t  out_data;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int          mismatches, outstanding, n_run, n_done, n_idle, n_full;
  logic [31:0] sched_time;

  // idling knobs, percent chance of starting an idle burst
  int          gap_pct = 0;
  int          stall_pct = 0;
  bit          quiet = 1'b0;
  int          cycles = 0;
  int          reqs_sent = 0;
  logic [15:0] cur_quantum = QUANTUM_RESET;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  priority_quantum_scheduler #(.MAX_PROCS(SLOTS)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  pqs_checker #(.SLOTS(SLOTS)) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .sched_time  (sched_time),
    .n_run       (n_run),
    .n_done      (n_done),
    .n_idle      (n_idle),
    .n_full      (n_full)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result-side backpressure: random stall bursts, one assignment per edge
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold == 0 && !quiet && $urandom_range(0, 99) < stall_pct)
        hold = $urandom_range(1, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Present one request and hold it until taken. Valid is only dropped when a
  // sender gap follows, so back-to-back requests never toggle it within a step.
  task automatic send_req(input sched_in_t r);
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    reqs_sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic add_proc(input logic [7:0] id, input logic [15:0] arr,
                          input logic [15:0] burst, input logic [7:0] prio);
    sched_in_t r;
    r.cmd = CMD_ADD;
    r.proc_id = id;
    r.arrival_time = arr;
    r.burst_time = burst;
    r.priority_req = prio;
    send_req(r);
  endtask

  // only cmd matters for a slice; the rest is junk on purpose
  task automatic run_slice();
    sched_in_t r;
    r = sched_in_t'(IN_W'({$urandom, $urandom}));
    r.cmd = CMD_SLICE;
    send_req(r);
  endtask

  // stop sending and wait until every result has been drained
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // quantum writes only happen with the block idle
  task automatic set_quantum(input logic [15:0] q);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    cur_quantum = q;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mixed add/slice traffic. Arrivals mostly land just ahead of the current
  // time so processes actually become ready; bursts mostly scale with the
  // quantum so slices both finish and preempt.
  task automatic random_phase(input int count, input int add_pct);
    logic [32:0] guess;
    logic [15:0] arr, burst;
    logic [7:0]  prio;
    int          lim;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < add_pct) begin
        guess = {1'b0, sched_time} + 33'($urandom_range(0, 60));
        case ($urandom_range(0, 9))
          0:       arr = 16'($urandom);
          1:       arr = '0;
          2:       arr = 16'hFFFF;
          default: arr = (guess > 33'd65535) ? 16'($urandom) : guess[15:0];
        endcase
        lim = 3 * cur_quantum;
        if (lim > 65535) lim = 65535;
        case ($urandom_range(0, 15))
          0:       burst = '0;
          1:       burst = 16'hFFFF;
          2:       burst = 16'($urandom);
          default: burst = 16'($urandom_range(0, lim));
        endcase
        // narrow priority range so ties are common
        prio = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        add_proc(8'($urandom), arr, burst, prio);
      end else begin
        run_slice();
      end
    end
  endtask

  initial begin
    logic [15:0] phase_q [PHASES];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, quantum at its reset value of 1 ---
    gap_pct = 30;
    stall_pct = 30;
    run_slice();                                    // empty table, first slice pending: idle
    add_proc(8'hAA, 16'd300, 16'd5, 8'd9);
    add_proc(8'h55, 16'd100, 16'd0, 8'd0);          // ties earliest arrival, added first
    add_proc(8'hFF, 16'd100, 16'hFFFF, 8'hFF);
    run_slice();                                    // first slice: earliest, not yet arrived
    add_proc(8'h01, 16'd0, 16'd3, 8'd4);            // after first slice, no effect on pick
    run_slice();
    add_proc(8'h02, 16'd0, 16'd2, 8'd4);            // same priority, younger
    run_slice();
    add_proc(8'h00, 16'd0, 16'd0, 8'd0);            // zero burst finishes with no time used
    run_slice();
    for (int i = 0; i < 13; i++)                    // fill the table, last one refused
      add_proc(8'h10 + 8'(i), 16'($urandom_range(0, 40)), 16'($urandom_range(0, 6)),
               8'($urandom_range(0, 7)));
    run_slice();

    // --- random part: quantum sweeps small to large, extremes included ---
    phase_q = '{16'd1, 16'd7, 16'd2, 16'($urandom_range(1, 200)), 16'd300, 16'd40,
                16'd1, 16'($urandom_range(1, 5000)), 16'hFFFF, 16'd3};
    for (int p = 0; p < PHASES; p++) begin
      set_quantum(phase_q[p]);
      // every third phase runs without idling on either side
      gap_pct   = (p % 3 == 0) ? 0 : $urandom_range(10, 60);
      stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 60);
      random_phase(PHASE_REQS, $urandom_range(35, 65));
    end

    // --- closing part, no idling: long-quantum slices back to back ---
    quiet = 1'b1;
    set_quantum(16'hFFFF);
    for (int i = 0; i < SAT_SLICES; i++) run_slice();
    add_proc(8'h3C, 16'hFFFF, 16'hFFFF, 8'd0);
    run_slice();
    run_slice();

    settle();
    repeat (2 * SLICE_LAT) @(posedge clk);
    $display("tb: %0d requests, %0d slices dispatched (%0d completed), %0d idle slices",
             reqs_sent, n_run, n_done, n_idle);
    $display("tb: %0d adds refused on a full table, quantum swept 1..65535, final time %0d",
             n_full, sched_time);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
